### hdl/kti_pkg.sv
// ----------------------------------------------------------------------------
// kti_pkg
// Shared types and constants of the keyframe table interpolator.
// ----------------------------------------------------------------------------
package kti_pkg;

  localparam int KEYFRAMES_DEF = 64;

  localparam int CMD_W    = 3;
  localparam int TICK_W   = 31;
  localparam int VAL_W    = 32;
  localparam int MODE_W   = 3;
  localparam int IDX_W    = 8;
  localparam int FRAC_W   = 16;
  localparam int NFIELD   = 6;
  localparam int FIELD_IW = 3;

  localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DEL   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd2;
  localparam logic [CMD_W-1:0] CMD_EVAL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MODE  = 3'd4;

  localparam logic [MODE_W-1:0] MODE_NONE      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_KEYFRAMED = 3'd1;

  typedef logic [NFIELD-1:0][VAL_W-1:0] pose_t;

  typedef struct packed {
    logic [TICK_W-1:0] tick;
    logic [MODE_W-1:0] mode;
    pose_t             val;
  } key_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_INS_INIT,
    OP_INS_READ,
    OP_INS_MOVE,
    OP_INS_PUT,
    OP_DEL_INIT,
    OP_DEL_READ,
    OP_DEL_MOVE,
    OP_DEL_FIN,
    OP_CLEAR,
    OP_SETMODE,
    OP_EV_INIT,
    OP_EV_SCAN,
    OP_EV_DEC,
    OP_DIV,
    OP_MIX,
    OP_RESULT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic res_valid;
    logic res_acc;
  } ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             del_ok;
    logic             ptr_zero;
    logic             ins_shift;
    logic             del_last;
    logic             scan_done;
    logic             eval_ok;
    logic             need_div;
    logic             div_last;
    logic             mix_done;
    logic             out_free;
  } sts_t;

endpackage

### hdl/kti_ctrl.sv
// ----------------------------------------------------------------------------
// kti_ctrl
// Sequencer: steps the datapath through insert, delete, clear, set mode, scan, divide, mix and result.
// ----------------------------------------------------------------------------
module kti_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  kti_pkg::sts_t sts,
  output kti_pkg::ctl_t ctl
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_INS_RD, S_INS_CHK, S_INS_PUT, S_DEL_RD, S_DEL_MOVE,
    S_EV_SCAN, S_EV_DEC, S_DIV, S_MIX, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   res_valid_r, res_valid_nxt;
  logic   res_acc_r, res_acc_nxt;
  kti_pkg::op_t op;

  assign in_stall      = (state_r != S_IDLE);
  assign ctl.op        = op;
  assign ctl.res_valid = res_valid_r;
  assign ctl.res_acc   = res_acc_r;

  always_comb begin
    state_nxt     = state_r;
    res_valid_nxt = res_valid_r;
    res_acc_nxt   = res_acc_r;
    op            = kti_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = kti_pkg::OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        res_valid_nxt = 1'b0;
        res_acc_nxt   = 1'b1;
        state_nxt     = S_DONE;
        unique case (sts.cmd)
          kti_pkg::CMD_ADD: begin
            if (sts.full) begin
              res_acc_nxt = 1'b0;
            end else begin
              op        = kti_pkg::OP_INS_INIT;
              state_nxt = S_INS_RD;
            end
          end
          kti_pkg::CMD_DEL: begin
            if (sts.del_ok) begin
              op        = kti_pkg::OP_DEL_INIT;
              state_nxt = S_DEL_RD;
            end else begin
              res_acc_nxt = 1'b0;
            end
          end
          kti_pkg::CMD_CLEAR: op = kti_pkg::OP_CLEAR;
          kti_pkg::CMD_MODE:  op = kti_pkg::OP_SETMODE;
          kti_pkg::CMD_EVAL: begin
            op        = kti_pkg::OP_EV_INIT;
            state_nxt = S_EV_SCAN;
          end
          default: ;
        endcase
      end
      S_INS_RD: begin
        if (sts.ptr_zero) begin
          state_nxt = S_INS_PUT;
        end else begin
          op        = kti_pkg::OP_INS_READ;
          state_nxt = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        if (sts.ins_shift) begin
          op        = kti_pkg::OP_INS_MOVE;
          state_nxt = S_INS_RD;
        end else begin
          state_nxt = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        op        = kti_pkg::OP_INS_PUT;
        state_nxt = S_DONE;
      end
      S_DEL_RD: begin
        if (sts.del_last) begin
          op        = kti_pkg::OP_DEL_FIN;
          state_nxt = S_DONE;
        end else begin
          op        = kti_pkg::OP_DEL_READ;
          state_nxt = S_DEL_MOVE;
        end
      end
      S_DEL_MOVE: begin
        op        = kti_pkg::OP_DEL_MOVE;
        state_nxt = S_DEL_RD;
      end
      S_EV_SCAN: begin
        op = kti_pkg::OP_EV_SCAN;
        if (sts.scan_done) state_nxt = S_EV_DEC;
      end
      S_EV_DEC: begin
        if (sts.eval_ok) begin
          op            = kti_pkg::OP_EV_DEC;
          res_valid_nxt = 1'b1;
          state_nxt     = sts.need_div ? S_DIV : S_MIX;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        op = kti_pkg::OP_DIV;
        if (sts.div_last) state_nxt = S_MIX;
      end
      S_MIX: begin
        op = kti_pkg::OP_MIX;
        if (sts.mix_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          op        = kti_pkg::OP_RESULT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_valid_r <= 1'b0;
      res_acc_r   <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
      res_acc_r   <= res_acc_nxt;
    end
  end

endmodule

### hdl/kti_dp.sv
// ----------------------------------------------------------------------------
// kti_dp
// Datapath: keyframe memory, item registers, bracket scan, divider, mixer
// and the result register.
// ----------------------------------------------------------------------------
module kti_dp #(
  parameter int KEYFRAMES = kti_pkg::KEYFRAMES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  kti_pkg::ctl_t                       ctl,
  output kti_pkg::sts_t                       sts,
  input  logic [kti_pkg::CMD_W-1:0]           in_command,
  input  logic [kti_pkg::TICK_W-1:0]          in_tick,
  input  kti_pkg::pose_t                      in_pose,
  input  logic [kti_pkg::IDX_W-1:0]           in_index,
  input  logic [kti_pkg::MODE_W-1:0]          in_new_mode,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic                                out_camera_valid,
  output kti_pkg::pose_t                      out_pose,
  output logic                                out_accepted,
  output logic [kti_pkg::MODE_W-1:0]          out_mode_now,
  output logic [$clog2(KEYFRAMES+1)-1:0]      out_entry_count
);

  localparam int AW = $clog2(KEYFRAMES);
  localparam int CW = $clog2(KEYFRAMES + 1);
  localparam int WW = (CW > kti_pkg::IDX_W) ? CW : kti_pkg::IDX_W;
  localparam int TW = kti_pkg::TICK_W;
  localparam int FW = kti_pkg::FRAC_W;
  localparam int VW = kti_pkg::VAL_W;
  localparam int PW = VW + 1 + FW + 1;

  // item
  logic [kti_pkg::CMD_W-1:0]  cmd_r;
  logic [TW-1:0]              tick_r;
  kti_pkg::pose_t             pose_r;
  logic [kti_pkg::IDX_W-1:0]  idx_r;
  logic [kti_pkg::MODE_W-1:0] nmode_r;

  logic [CW-1:0]              count_r;
  logic [kti_pkg::MODE_W-1:0] mode_r;
  logic [CW-1:0]              ptr_r;

  kti_pkg::key_t mem [KEYFRAMES];
  kti_pkg::key_t rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          we;
  kti_pkg::key_t wr_data;

  // scan
  logic          scan_v_r;
  logic          has_prev_r, has_next_r;
  kti_pkg::key_t prev_r, next_r;

  // divider
  logic [TW-1:0] rem_r, den_r;
  logic [FW-1:0] q_r;
  logic [3:0]    div_cnt_r;
  logic [TW:0]   rem_sh;

  // mixer
  logic [kti_pkg::FIELD_IW-1:0] mk_r, kd_r, mk_sel;
  logic                         pv_r;
  logic signed [PW-1:0]         prod_r;
  logic signed [VW:0]           diff;
  logic signed [PW-1:0]         prod_nxt, prod_sh, sum_w;
  kti_pkg::pose_t               res_r;

  // result register
  logic                       out_valid_r;
  logic                       ocv_r, oacc_r;
  kti_pkg::pose_t             opose_r;
  logic [kti_pkg::MODE_W-1:0] omode_r;
  logic [CW-1:0]              ocount_r;

  logic [WW-1:0] idx_w, count_w;
  logic [CW-1:0] ptr_m1, ptr_p1;

  assign idx_w   = WW'(idx_r);
  assign count_w = WW'(count_r);
  assign ptr_m1  = ptr_r - CW'(1);
  assign ptr_p1  = ptr_r + CW'(1);

  always_comb begin
    case (ctl.op)
      kti_pkg::OP_INS_READ: rd_addr = ptr_m1[AW-1:0];
      kti_pkg::OP_DEL_READ: rd_addr = ptr_p1[AW-1:0];
      default:              rd_addr = ptr_r[AW-1:0];
    endcase
  end

  assign we = (ctl.op == kti_pkg::OP_INS_MOVE) || (ctl.op == kti_pkg::OP_INS_PUT) ||
              (ctl.op == kti_pkg::OP_DEL_MOVE);

  always_comb begin
    if (ctl.op == kti_pkg::OP_INS_PUT) begin
      wr_data.tick = tick_r;
      wr_data.mode = mode_r;
      wr_data.val  = pose_r;
    end else begin
      wr_data = rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[ptr_r[AW-1:0]] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  // one restoring step per cycle
  assign rem_sh = {rem_r, 1'b0};

  assign mk_sel   = (mk_r < kti_pkg::FIELD_IW'(kti_pkg::NFIELD)) ? mk_r : '0;
  assign diff     = $signed({next_r.val[mk_sel][VW-1], next_r.val[mk_sel]}) -
                    $signed({prev_r.val[mk_sel][VW-1], prev_r.val[mk_sel]});
  assign prod_nxt = diff * $signed({1'b0, q_r});
  assign prod_sh  = prod_r >>> FW;
  assign sum_w    = $signed({{(PW-VW){prev_r.val[kd_r][VW-1]}}, prev_r.val[kd_r]}) + prod_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      mode_r      <= kti_pkg::MODE_NONE;
      scan_v_r    <= 1'b0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      scan_v_r <= (ctl.op == kti_pkg::OP_EV_SCAN) && (ptr_r < count_r);
      pv_r     <= (ctl.op == kti_pkg::OP_MIX) &&
                  (mk_r < kti_pkg::FIELD_IW'(kti_pkg::NFIELD));
      if (!out_stall) out_valid_r <= 1'b0;

      if (scan_v_r) begin
        if (rd_data_r.tick == tick_r && rd_data_r.mode != kti_pkg::MODE_NONE)
          mode_r <= rd_data_r.mode;
        if (rd_data_r.tick <= tick_r) begin
          prev_r     <= rd_data_r;
          has_prev_r <= 1'b1;
        end
        if (rd_data_r.tick >= tick_r && !has_next_r) begin
          next_r     <= rd_data_r;
          has_next_r <= 1'b1;
        end
      end

      if (pv_r) res_r[kd_r] <= sum_w[VW-1:0];

      case (ctl.op)
        kti_pkg::OP_LOAD: begin
          cmd_r   <= in_command;
          tick_r  <= in_tick;
          pose_r  <= in_pose;
          idx_r   <= in_index;
          nmode_r <= in_new_mode;
        end
        kti_pkg::OP_INS_INIT: ptr_r <= count_r;
        kti_pkg::OP_INS_MOVE: ptr_r <= ptr_m1;
        kti_pkg::OP_INS_PUT:  count_r <= count_r + CW'(1);
        kti_pkg::OP_DEL_INIT: ptr_r <= idx_w[CW-1:0];
        kti_pkg::OP_DEL_MOVE: ptr_r <= ptr_p1;
        kti_pkg::OP_DEL_FIN:  count_r <= count_r - CW'(1);
        kti_pkg::OP_CLEAR:    count_r <= '0;
        kti_pkg::OP_SETMODE:  mode_r <= nmode_r;
        kti_pkg::OP_EV_INIT: begin
          ptr_r      <= '0;
          has_prev_r <= 1'b0;
          has_next_r <= 1'b0;
        end
        kti_pkg::OP_EV_SCAN: begin
          if (ptr_r < count_r) ptr_r <= ptr_p1;
        end
        kti_pkg::OP_EV_DEC: begin
          mk_r      <= '0;
          q_r       <= '0;
          div_cnt_r <= '0;
          rem_r     <= tick_r - prev_r.tick;
          den_r     <= next_r.tick - prev_r.tick;
          if (!sts.need_div) begin
            // edge or equal ticks: mix with a zero fraction gives the entry
            prev_r <= has_prev_r ? prev_r : next_r;
            next_r <= has_prev_r ? prev_r : next_r;
          end
        end
        kti_pkg::OP_DIV: begin
          div_cnt_r <= div_cnt_r + 4'd1;
          if (rem_sh >= {1'b0, den_r}) begin
            rem_r <= TW'(rem_sh - {1'b0, den_r});
            q_r   <= {q_r[FW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh[TW-1:0];
            q_r   <= {q_r[FW-2:0], 1'b0};
          end
        end
        kti_pkg::OP_MIX: begin
          prod_r <= prod_nxt;
          kd_r   <= mk_sel;
          mk_r   <= mk_r + kti_pkg::FIELD_IW'(1);
        end
        kti_pkg::OP_RESULT: begin
          out_valid_r <= 1'b1;
          ocv_r       <= ctl.res_valid;
          oacc_r      <= ctl.res_acc;
          opose_r     <= ctl.res_valid ? res_r : '0;
          omode_r     <= mode_r;
          ocount_r    <= count_r;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    sts.cmd       = cmd_r;
    sts.full      = (count_r == CW'(KEYFRAMES));
    sts.del_ok    = (idx_w < count_w);
    sts.ptr_zero  = (ptr_r == '0);
    sts.ins_shift = (rd_data_r.tick > tick_r);
    sts.del_last  = (ptr_p1 >= count_r);
    sts.scan_done = (ptr_r >= count_r) && !scan_v_r;
    sts.eval_ok   = (mode_r == kti_pkg::MODE_KEYFRAMED) && (count_r >= CW'(2));
    sts.need_div  = has_prev_r && has_next_r && (prev_r.tick != next_r.tick);
    sts.div_last  = (div_cnt_r == 4'(FW - 1));
    sts.mix_done  = pv_r && (kd_r == kti_pkg::FIELD_IW'(kti_pkg::NFIELD - 1));
    sts.out_free  = !out_valid_r || !out_stall;
  end

  assign out_valid        = out_valid_r;
  assign out_camera_valid = ocv_r;
  assign out_pose         = opose_r;
  assign out_accepted     = oacc_r;
  assign out_mode_now     = omode_r;
  assign out_entry_count  = ocount_r;

endmodule

### hdl/keyframe_table_interpolator.sv
// ----------------------------------------------------------------------------
// keyframe_table_interpolator
// Sorted camera keyframe table with piecewise linear pose evaluation.
// ----------------------------------------------------------------------------
// Input channel in_*: one command per transaction (add, delete, clear,
// evaluate, set mode). Output channel out_*: exactly one result transaction
// per command, in order. Both use valid/stall; a transaction completes when
// valid is high and stall is low.
// One command is worked at a time; in_stall is high from acceptance until the
// result is loaded into the output register. Steps per command:
//   add      : shift each entry above the new tick up one place, then write it
//   delete   : shift each entry above the index down one place
//   evaluate : scan for the bracket, decide, fraction divider (one quotient
//              bit a cycle), shared multiplier lane, load; an edge key skips
//              the divider, a result without pose skips both
//   others, rejected add or delete : load the result directly
// The keyframe memory (one read, one write a cycle) sets the
// insert/delete walk and the scan rate.
// A new command can be taken while the previous result waits; if out_stall
// holds that result, the next one waits in the controller.
// Reset empties the table and sets the mode to none; no clearing pass.
// ----------------------------------------------------------------------------
module keyframe_table_interpolator #(
  parameter int KEYFRAMES = kti_pkg::KEYFRAMES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [kti_pkg::CMD_W-1:0]          in_command,
  input  logic [kti_pkg::TICK_W-1:0]         in_tick,
  input  logic signed [kti_pkg::VAL_W-1:0]   in_pos_x,
  input  logic signed [kti_pkg::VAL_W-1:0]   in_pos_y,
  input  logic signed [kti_pkg::VAL_W-1:0]   in_pos_z,
  input  logic signed [kti_pkg::VAL_W-1:0]   in_yaw_in,
  input  logic signed [kti_pkg::VAL_W-1:0]   in_pitch_in,
  input  logic signed [kti_pkg::VAL_W-1:0]   in_fov_in,
  input  logic [kti_pkg::IDX_W-1:0]          in_index,
  input  logic [kti_pkg::MODE_W-1:0]         in_new_mode,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_camera_valid,
  output logic signed [kti_pkg::VAL_W-1:0]   out_x,
  output logic signed [kti_pkg::VAL_W-1:0]   out_y,
  output logic signed [kti_pkg::VAL_W-1:0]   out_z,
  output logic signed [kti_pkg::VAL_W-1:0]   out_yaw,
  output logic signed [kti_pkg::VAL_W-1:0]   out_pitch,
  output logic signed [kti_pkg::VAL_W-1:0]   out_fov,
  output logic                               out_accepted,
  output logic [kti_pkg::MODE_W-1:0]         out_mode_now,
  output logic [$clog2(KEYFRAMES+1)-1:0]     out_entry_count
);

  kti_pkg::ctl_t  ctl;
  kti_pkg::sts_t  sts;
  kti_pkg::pose_t in_pose, out_pose;

  assign in_pose = {in_fov_in, in_pitch_in, in_yaw_in, in_pos_z, in_pos_y, in_pos_x};

  assign out_x     = out_pose[0];
  assign out_y     = out_pose[1];
  assign out_z     = out_pose[2];
  assign out_yaw   = out_pose[3];
  assign out_pitch = out_pose[4];
  assign out_fov   = out_pose[5];

  kti_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  kti_dp #(
    .KEYFRAMES (KEYFRAMES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .sts              (sts),
    .in_command       (in_command),
    .in_tick          (in_tick),
    .in_pose          (in_pose),
    .in_index         (in_index),
    .in_new_mode      (in_new_mode),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_camera_valid (out_camera_valid),
    .out_pose         (out_pose),
    .out_accepted     (out_accepted),
    .out_mode_now     (out_mode_now),
    .out_entry_count  (out_entry_count)
  );

  // a new result never overwrites one still held by the receiver
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == kti_pkg::OP_RESULT) |-> !(out_valid && out_stall))
    else $error("result register overwritten while stalled");

  // a result without a pose carries a zero pose
  a_zero_pose: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_camera_valid) |-> (out_pose == '0))
    else $error("pose nonzero on result without camera");

  // the table never grows past its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_count <= ($clog2(KEYFRAMES+1))'(KEYFRAMES)))
    else $error("entry count beyond table depth");

  // no command is taken while one is in progress
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == kti_pkg::OP_LOAD) |=> in_stall)
    else $error("controller did not hold off the input");

endmodule
